FILE: rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/mmsi_pkg.sv
// Types and constants of the multi-motor setpoint interpolator.
// Used by mmsi_ctrl, mmsi_dp and the top level; depends on nothing.
package mmsi_pkg;

	localparam int SLOT_BYTES  = 7;
	localparam int ID_OFFSET   = 56;
	localparam int FRAME_BYTES = 64;
	localparam int CFG_INDEX_W = 3;

	localparam logic [16:0] ALPHA_ONE        = 17'h10000;
	localparam logic [7:0]  CTRL_SHORT_FIRST = 8'hD8;
	localparam logic [7:0]  CTRL_SHORT_LATER = 8'hD0;
	localparam logic [2:0]  LAST_WORD        = 3'd7;

	// request codes
	localparam logic [1:0] REQ_SET_TARGET = 2'd0;
	localparam logic [1:0] REQ_COMMIT     = 2'd1;
	localparam logic [1:0] REQ_TICK       = 2'd2;
	localparam logic [1:0] REQ_PRESET     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_PROTOCOL    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CSP_FIRST_CONTROL = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CSP_CONTROL       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR_COUNT       = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR_ID_LIST     = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         motor_index;
		logic signed [15:0] position_counts;
		logic [16:0]        alpha_step;
	} req_t;

	typedef struct packed {
		logic [2:0]  word_index;
		logic [63:0] frame_word;
		logic        last_word;
	} word_t;

	typedef struct packed {
		logic        short_protocol;
		logic [7:0]  csp_first_control;
		logic [7:0]  csp_control;
		logic [3:0]  motors_used;
		logic [63:0] motor_id_list;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       alpha_upd;
		logic       issue;
		logic [2:0] issue_idx;
		logic       load_word;
		logic [2:0] word_idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [3:0] count;
		logic       out_free;
	} sts_t;

endpackage

FILE: rtl/mmsi_ctrl.sv
// Sequencer of the interpolator: takes requests, walks the motors of a tick
// and paces the eight frame words. Depends on mmsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmsi_ctrl import mmsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] req_type,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ALPHA = 5'b00010,
		S_CALC  = 5'b00100,
		S_DRAIN = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] motor_q, motor_d;
	logic [2:0] word_q, word_d;

	always_comb begin
		state_d = state_q;
		motor_d = motor_q;
		word_d  = word_q;
		cmd     = '0;
		cmd.issue_idx = motor_q;
		cmd.word_idx  = word_q;
		req_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
				if (req_valid && req_type == REQ_TICK) begin
					state_d = S_ALPHA;
				end
			end
			S_ALPHA: begin
				cmd.alpha_upd = 1'b1;
				motor_d = '0;
				word_d  = '0;
				if (sts.count == 4'd0) begin
					state_d = S_EMIT;
				end else begin
					state_d = S_CALC;
				end
			end
			S_CALC: begin
				cmd.issue = 1'b1;
				motor_d = motor_q + 3'd1;
				if ({1'b0, motor_q} == sts.count - 4'd1) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.load_word = 1'b1;
					word_d = word_q + 3'd1;
					if (word_q == LAST_WORD) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			motor_q <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			motor_q <= motor_d;
			word_q  <= word_d;
		end
	end

	`ASSERT_SAME(a_issue_in_range, cmd.issue, {1'b0, motor_q} < sts.count)
	`ASSERT_NEXT(a_last_word_ends_tick, cmd.load_word && word_q == LAST_WORD, state_q == S_IDLE)
	`ASSERT_NEXT(a_alpha_then_work, cmd.alpha_upd, state_q == S_CALC || state_q == S_EMIT)

endmodule

FILE: rtl/mmsi_dp.sv
// Datapath of the interpolator: position stores, alpha, one multiplier
// stage, frame assembly and the output word register. Depends on mmsi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mmsi_dp import mmsi_pkg::*; #(
	parameter int MAX_MOTORS = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cfg_t  cfg,
	input  cmd_t  cmd,
	output sts_t  sts,
	output logic  word_valid,
	input  logic  word_stall,
	output word_t word_data
);

	localparam int         IDX_W  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
	localparam logic [3:0] MOT_N  = 4'(MAX_MOTORS);

	logic [15:0] start_q  [MAX_MOTORS];
	logic [15:0] target_q [MAX_MOTORS];
	logic [15:0] sent_q   [MAX_MOTORS];
	logic [16:0] alpha_q, inc_q;
	logic        first_q;

	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [15:0]        start_s1;
	logic signed [34:0] prod_s1;

	logic               out_valid_q;
	word_t              out_q;

	logic [3:0]         count;
	logic [17:0]        alpha_sum;
	logic [IDX_W-1:0]   req_idx, issue_idx;
	logic               req_idx_ok;
	logic signed [16:0] diff;
	logic signed [34:0] prod;
	logic signed [34:0] total, rounded;
	logic [15:0]        new_pos;
	logic [7:0]         ctrl;
	logic [7:0]         frame [FRAME_BYTES];
	logic [63:0]        word_bits;

	assign count = (cfg.motors_used > MOT_N) ? MOT_N : cfg.motors_used;
	assign sts.count    = count;
	assign sts.out_free = !out_valid_q || !word_stall;

	assign alpha_sum  = {1'b0, alpha_q} + {1'b0, inc_q};
	assign req_idx    = req.motor_index[IDX_W-1:0];
	assign req_idx_ok = {1'b0, req.motor_index} < MOT_N;
	assign issue_idx  = cmd.issue_idx[IDX_W-1:0];

	// target - start, then scale by alpha
	assign diff = $signed({target_q[issue_idx][15], target_q[issue_idx]})
		- $signed({start_q[issue_idx][15], start_q[issue_idx]});
	assign prod = diff * $signed({1'b0, alpha_q});

	// start*1.0 + product, truncated toward zero
	assign total   = $signed({{3{start_s1[15]}}, start_s1, 16'h0000}) + prod_s1;
	assign rounded = total + (total[34] ? 35'sh0FFFF : 35'sh0);
	assign new_pos = rounded[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_MOTORS; i++) begin
				start_q[i]  <= '0;
				target_q[i] <= '0;
				sent_q[i]   <= '0;
			end
			alpha_q  <= '0;
			inc_q    <= '0;
			first_q  <= 1'b1;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.accept) begin
				case (req.req_type)
					REQ_SET_TARGET: begin
						if (req_idx_ok) begin
							target_q[req_idx] <= req.position_counts;
						end
					end
					REQ_COMMIT: begin
						for (int i = 0; i < MAX_MOTORS; i++) begin
							start_q[i] <= sent_q[i];
						end
						alpha_q <= '0;
						inc_q   <= req.alpha_step;
					end
					REQ_PRESET: begin
						if (req_idx_ok) begin
							start_q[req_idx]  <= req.position_counts;
							target_q[req_idx] <= req.position_counts;
							sent_q[req_idx]   <= req.position_counts;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.alpha_upd) begin
				// clamp at 1.0
				alpha_q <= (alpha_sum > {1'b0, ALPHA_ONE}) ? ALPHA_ONE : alpha_sum[16:0];
			end
			if (valid_s1) begin
				sent_q[idx_s1] <= new_pos;
			end
			if (cmd.load_word && cmd.word_idx == LAST_WORD) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1   <= issue_idx;
			start_s1 <= start_q[issue_idx];
			prod_s1  <= prod;
		end
	end

	always_comb begin
		if (cfg.short_protocol) begin
			ctrl = first_q ? CTRL_SHORT_FIRST : CTRL_SHORT_LATER;
		end else begin
			ctrl = first_q ? cfg.csp_first_control : cfg.csp_control;
		end
	end

	always_comb begin
		for (int b = 0; b < FRAME_BYTES; b++) begin
			frame[b] = 8'h00;
		end
		for (int i = 0; i < MAX_MOTORS; i++) begin
			if (4'(i) < count) begin
				frame[SLOT_BYTES*i]     = ctrl;
				frame[SLOT_BYTES*i + 1] = sent_q[i][15:8];
				frame[SLOT_BYTES*i + 2] = sent_q[i][7:0];
				frame[ID_OFFSET + i]    = cfg.motor_id_list[8*i +: 8];
			end
		end
		for (int b = 0; b < 8; b++) begin
			word_bits[63-8*b -: 8] = frame[{cmd.word_idx, 3'(b)}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_word) begin
			out_valid_q <= 1'b1;
		end else if (!word_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			out_q.word_index <= cmd.word_idx;
			out_q.frame_word <= word_bits;
			out_q.last_word  <= (cmd.word_idx == LAST_WORD);
		end
	end

	assign word_valid = out_valid_q;
	assign word_data  = out_q;

	`ASSERT_ALWAYS(a_alpha_clamped, alpha_q <= ALPHA_ONE)
	`ASSERT_NEXT(a_first_cleared, cmd.load_word && cmd.word_idx == LAST_WORD, !first_q)
	`ASSERT_SAME(a_load_only_when_free, cmd.load_word, sts.out_free)

endmodule

FILE: rtl/multi_motor_setpoint_interpolator.sv
// Top level of the multi-motor setpoint interpolator.
// Holds the configuration registers; depends on mmsi_pkg, mmsi_ctrl, mmsi_dp.
// req channel (req_valid / req_stall / req_data): one request per handshake:
//   set target, commit segment, preset position or tick.
// word channel (word_valid / word_stall / word_data): eight 64-bit frame words
//   per tick, word 0 first, last_word set on word 7; none for other requests.
// cfg port (cfg_we / cfg_index / cfg_wdata): write-only, one register per cycle,
//   indexes beyond the list are dropped. Write only while idle.
// Set target, commit and preset take effect at the accept edge; the next request
//   can be taken in the following cycle.
// A tick updates alpha, runs one motor per cycle through a single multiplier
//   stage, lets the last result reach the position store in a drain state,
//   then loads one word per cycle into the output register while the receiver
//   does not stall. With no motor in use the multiplier pass is skipped.
// When the receiver stalls, hold the output word and pause the sequence;
//   req_stall stays high until word 7 has been loaded.
// Reset: positions, alpha and its step go to zero, the first-frame flag is set,
//   the motor count register resets to 8 and the others to zero.
module multi_motor_setpoint_interpolator import mmsi_pkg::*; #(
	parameter int MAX_MOTORS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  req_t                   req_data,
	output logic                   word_valid,
	input  logic                   word_stall,
	output word_t                  word_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_wdata
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	// configuration registers; the user must write them only while idle, which the block does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_protocol    <= 1'b0;
			cfg_q.csp_first_control <= 8'h00;
			cfg_q.csp_control       <= 8'h00;
			cfg_q.motors_used       <= 4'd8;
			cfg_q.motor_id_list     <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_PROTOCOL:    cfg_q.short_protocol    <= cfg_wdata[0];
				CFG_CSP_FIRST_CONTROL: cfg_q.csp_first_control <= cfg_wdata[7:0];
				CFG_CSP_CONTROL:       cfg_q.csp_control       <= cfg_wdata[7:0];
				CFG_MOTOR_COUNT:       cfg_q.motors_used       <= cfg_wdata[3:0];
				CFG_MOTOR_ID_LIST:     cfg_q.motor_id_list     <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// sequencer: accepts requests and steps through the tick
	mmsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_data.req_type),
		.sts       (sts),
		.cmd       (cmd)
	);

	// stores, interpolation and frame words
	mmsi_dp #(
		.MAX_MOTORS (MAX_MOTORS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_data),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.sts        (sts),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

endmodule

FILE: tb/mmsi_checker.sv
`timescale 1ns / 1ps
// Frame scoreboard for multi_motor_setpoint_interpolator: follows register writes and
// requests, predicts the eight frame words of every tick and compares them in order.
// Depends on mmsi_pkg.
module mmsi_checker import mmsi_pkg::*; #(
	parameter int MAX_MOTORS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_stall,
	input  req_t                   req_data,
	input  logic                   word_valid,
	input  logic                   word_stall,
	input  word_t                  word_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0]            cfg_wdata,
	output int                     mismatches,
	output int                     words_checked,
	output int                     words_pending
);

	logic               short_protocol;
	logic [7:0]         first_ctrl;
	logic [7:0]         later_ctrl;
	logic [3:0]         motors_in_use;
	logic [63:0]        id_bytes;
	logic signed [15:0] seg_start [MAX_MOTORS];
	logic signed [15:0] seg_target [MAX_MOTORS];
	logic signed [15:0] last_sent [MAX_MOTORS];
	int unsigned        alpha;
	int unsigned        alpha_step;
	logic               first_frame;
	word_t              expected_words [$];

	// start + alpha * (target - start), alpha in Q1.16, truncated toward zero
	function automatic logic signed [15:0] blend_position(input logic signed [15:0] from,
		input logic signed [15:0] to, input int unsigned a);
		longint s;
		longint d;
		longint total;
		longint q;
		s = from;
		d = longint'(to) - s;
		total = s * longint'(ALPHA_ONE) + d * longint'(a);
		if (total < 0)
			q = -((-total) >>> 16);
		else
			q = total >>> 16;
		return q[15:0];
	endfunction

	function automatic void predict_frame();
		logic [7:0]         frame [FRAME_BYTES];
		int                 count;
		logic [7:0]         ctrl;
		logic signed [15:0] p;
		word_t              w;
		alpha = alpha + alpha_step;
		if (alpha > ALPHA_ONE)
			alpha = ALPHA_ONE;
		count = (motors_in_use > MAX_MOTORS) ? MAX_MOTORS : motors_in_use;
		if (short_protocol)
			ctrl = first_frame ? CTRL_SHORT_FIRST : CTRL_SHORT_LATER;
		else
			ctrl = first_frame ? first_ctrl : later_ctrl;
		for (int b = 0; b < FRAME_BYTES; b++)
			frame[b] = '0;
		for (int i = 0; i < count; i++) begin
			p = blend_position(seg_start[i], seg_target[i], alpha);
			last_sent[i] = p;
			frame[i * SLOT_BYTES]     = ctrl;
			frame[i * SLOT_BYTES + 1] = p[15:8];
			frame[i * SLOT_BYTES + 2] = p[7:0];
			frame[ID_OFFSET + i]      = id_bytes[8 * i +: 8];
		end
		first_frame = 1'b0;
		// lowest-numbered byte goes to the top of each word
		for (int k = 0; k < FRAME_BYTES / 8; k++) begin
			w.word_index = k[2:0];
			w.frame_word = '0;
			for (int b = 0; b < 8; b++)
				w.frame_word = {w.frame_word[55:0], frame[8 * k + b]};
			w.last_word = (w.word_index == LAST_WORD);
			expected_words = {expected_words, w};
		end
	endfunction

	function automatic void apply_request(input req_t r);
		case (r.req_type)
			REQ_SET_TARGET: begin
				if (r.motor_index < MAX_MOTORS)
					seg_target[r.motor_index] = r.position_counts;
			end
			REQ_COMMIT: begin
				for (int i = 0; i < MAX_MOTORS; i++)
					seg_start[i] = last_sent[i];
				alpha = 0;
				alpha_step = r.alpha_step;
			end
			REQ_PRESET: begin
				if (r.motor_index < MAX_MOTORS) begin
					seg_start[r.motor_index]  = r.position_counts;
					seg_target[r.motor_index] = r.position_counts;
					last_sent[r.motor_index]  = r.position_counts;
				end
			end
			REQ_TICK: predict_frame();
			default: ;
		endcase
	endfunction

	function automatic void check_word(input word_t got);
		word_t want;
		if (expected_words.size() == 0) begin
			$error("unexpected frame word: word_index %0d frame_word %h last_word %0d",
				got.word_index, got.frame_word, got.last_word);
			mismatches++;
			return;
		end
		want = expected_words.pop_front();
		words_checked++;
		if (got.word_index !== want.word_index) begin
			$error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
			mismatches++;
		end
		if (got.frame_word !== want.frame_word) begin
			$error("frame_word (word %0d): expected %h, got %h", want.word_index,
				want.frame_word, got.frame_word);
			mismatches++;
		end
		if (got.last_word !== want.last_word) begin
			$error("last_word (word %0d): expected %0d, got %0d", want.word_index,
				want.last_word, got.last_word);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_protocol = 1'b0;
			first_ctrl = '0;
			later_ctrl = '0;
			motors_in_use = 4'd8;
			id_bytes = '0;
			for (int i = 0; i < MAX_MOTORS; i++) begin
				seg_start[i] = '0;
				seg_target[i] = '0;
				last_sent[i] = '0;
			end
			alpha = 0;
			alpha_step = 0;
			first_frame = 1'b1;
			expected_words.delete();
			mismatches = 0;
			words_checked = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SHORT_PROTOCOL:    short_protocol = cfg_wdata[0];
					CFG_CSP_FIRST_CONTROL: first_ctrl = cfg_wdata[7:0];
					CFG_CSP_CONTROL:       later_ctrl = cfg_wdata[7:0];
					CFG_MOTOR_COUNT:       motors_in_use = cfg_wdata[3:0];
					CFG_MOTOR_ID_LIST:     id_bytes = cfg_wdata;
					default: ;
				endcase
			end
			if (word_valid && !word_stall)
				check_word(word_data);
			if (req_valid && !req_stall)
				apply_request(req_data);
		end
		words_pending = expected_words.size();
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Top of the multi_motor_setpoint_interpolator testbench: clock, reset, register
// settings, request stimulus, receiver stalls and the verdict.
// Depends on mmsi_pkg, the RTL top level and mmsi_checker.
module tb;
	import mmsi_pkg::*;

	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off that fills the block
	localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
	localparam int DRAIN_CYCLES   = 24;    // settling time after the last predicted word
	localparam int MAX_GAP        = 18;
	localparam int POS_LIMIT      = 32668;

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_stall;
	req_t                   req_data;
	logic                   word_valid;
	logic                   word_stall;
	word_t                  word_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [63:0]            cfg_wdata;

	int   mismatches;
	int   words_checked;
	int   words_pending;
	int   requests_sent;
	int   ticks_sent;
	int   settings_used;
	int   gap_pct;
	int   stuck_cycles;
	logic quiet;        // no idling on either side
	logic pressure_go;  // ask the receiver for its long hold-off

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	multi_motor_setpoint_interpolator uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req_data   (req_data),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	mmsi_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_data      (req_data),
		.word_valid    (word_valid),
		.word_stall    (word_stall),
		.word_data     (word_data),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatches),
		.words_checked (words_checked),
		.words_pending (words_pending)
	);

	// Abort when no request, frame word or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (word_valid && !word_stall) || cfg_we) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", stuck_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Receiver: random stall and free bursts, one long hold-off on request, none
	// once the run goes quiet. Each burst length is counted here.
	initial begin : receiver_stalls
		int   burst;
		logic held;
		word_stall = 1'b0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_go && !held) begin
				// hold off long enough that the block backs up into the request side
				word_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				word_stall <= 1'b0;
				held = 1'b1;
			end else if (quiet) begin
				word_stall <= 1'b0;
			end else begin
				burst = $urandom_range(1, MAX_GAP);
				word_stall <= ($urandom_range(0, 2) == 0);
				repeat (burst - 1) @(negedge clk);
			end
		end
	end

	function automatic req_t make_req(input logic [1:0] kind, input logic [2:0] idx,
		input logic signed [15:0] pos, input logic [16:0] step);
		req_t r;
		r.req_type = kind;
		r.motor_index = idx;
		r.position_counts = pos;
		r.alpha_step = step;
		return r;
	endfunction

	// Position across the legal span, with the extremes now and then.
	function automatic logic signed [15:0] rand_pos();
		int v;
		case ($urandom_range(0, 9))
			0: v = POS_LIMIT;
			1: v = -POS_LIMIT;
			default: v = $urandom_range(0, 2 * POS_LIMIT) - POS_LIMIT;
		endcase
		return v[15:0];
	endfunction

	// Mix of slow ramps, single-tick jumps, mid-size steps and any step up to 1.0.
	function automatic logic [16:0] random_step();
		case ($urandom_range(0, 4))
			0: return 17'($urandom_range(0, 2048));
			1: return ALPHA_ONE;
			2: return 17'($urandom_range(8192, 32768));
			default: return 17'($urandom_range(0, ALPHA_ONE));
		endcase
	endfunction

	// Present one request at the falling edge and hold it until taken; then
	// maybe drop valid for a random gap.
	task automatic send_request(input req_t r);
		req_data <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		requests_sent++;
		if (r.req_type == REQ_TICK)
			ticks_sent++;
		if (!quiet && $urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
		end
	endtask

	// One register write; the caller lowers cfg_we after the last one.
	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
	endtask

	task automatic configure(input logic sp, input logic [7:0] first, input logic [7:0] later,
		input logic [3:0] count, input logic [63:0] ids);
		write_cfg(CFG_SHORT_PROTOCOL, {63'd0, sp});
		write_cfg(CFG_CSP_FIRST_CONTROL, {56'd0, first});
		write_cfg(CFG_CSP_CONTROL, {56'd0, later});
		write_cfg(CFG_MOTOR_COUNT, {60'd0, count});
		write_cfg(CFG_MOTOR_ID_LIST, ids);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Drop valid, wait for every predicted word, then let the block settle.
	task automatic finish_phase();
		req_valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly whole segments (targets or presets, commit, ticks) with random content, the
	// rest single requests of any kind.
	task automatic run_random(input int items);
		int done_items;
		int n;
		int m;
		done_items = 0;
		while (done_items < items) begin
			if ($urandom_range(0, 3) != 0) begin
				n = $urandom_range(1, 4);
				repeat (n)
					send_request(make_req(($urandom_range(0, 4) == 0) ? REQ_PRESET : REQ_SET_TARGET,
						3'($urandom_range(0, 7)), rand_pos(), random_step()));
				send_request(make_req(REQ_COMMIT, 3'($urandom_range(0, 7)), rand_pos(),
					random_step()));
				m = $urandom_range(1, 5);
				repeat (m)
					send_request(make_req(REQ_TICK, 3'($urandom_range(0, 7)), rand_pos(),
						random_step()));
				done_items += n + 1 + m;
			end else begin
				send_request(make_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					rand_pos(), 17'($urandom_range(0, ALPHA_ONE))));
				done_items++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		quiet = 1'b0;
		pressure_go = 1'b0;
		gap_pct = 25;
		requests_sent = 0;
		ticks_sent = 0;
		settings_used = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Short protocol before the first tick so the first-frame byte shows up;
		// motor count and the later control byte stay at their reset values.
		write_cfg(CFG_SHORT_PROTOCOL, 64'd1);
		write_cfg(CFG_CSP_FIRST_CONTROL, {56'd0, 8'($urandom)});
		write_cfg(CFG_MOTOR_ID_LIST, {$urandom, $urandom});
		cfg_we <= 1'b0;
		settings_used++;

		// Directed: position extremes, every request kind, zero step, a one-count
		// step that truncates toward zero, a step above 1.0 that clamps.
		send_request(make_req(REQ_PRESET, 3'd0, 16'(POS_LIMIT), '0));
		send_request(make_req(REQ_PRESET, 3'd1, 16'(-POS_LIMIT), '0));
		send_request(make_req(REQ_PRESET, 3'd7, -16'sd1, '0));
		send_request(make_req(REQ_SET_TARGET, 3'd0, 16'(-POS_LIMIT), '0));
		send_request(make_req(REQ_SET_TARGET, 3'd1, 16'(POS_LIMIT), '0));
		send_request(make_req(REQ_SET_TARGET, 3'd2, 16'sd777, '0));
		send_request(make_req(REQ_SET_TARGET, 3'd7, 16'(POS_LIMIT), '0));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_COMMIT, 3'd0, '0, 17'd16384));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_COMMIT, 3'd0, '0, '0));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_SET_TARGET, 3'd3, -16'sd3, '0));
		send_request(make_req(REQ_COMMIT, 3'd0, '0, 17'd1));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_COMMIT, 3'd0, '0, 17'h1FFFF));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_TICK, 3'd0, '0, '0));
		send_request(make_req(REQ_COMMIT, 3'd0, '0, ALPHA_ONE));
		send_request(make_req(REQ_TICK, 3'd7, -16'sd1, 17'h1FFFF));
		finish_phase();

		// No motors in use; writes past the register list must be dropped.
		for (int i = CFG_MOTOR_ID_LIST + 1; i < 2 ** CFG_INDEX_W; i++)
			write_cfg(i[CFG_INDEX_W-1:0], {$urandom, $urandom});
		configure(1'b0, 8'($urandom), 8'hFF, 4'd0, {$urandom, $urandom});
		run_random(10);
		finish_phase();

		// Count above the motor limit saturates; start with the long hold-off
		// while ticks keep coming.
		configure(1'b0, 8'hFF, 8'h00, 4'd15, {$urandom, $urandom});
		pressure_go <= 1'b1;
		repeat (3)
			send_request(make_req(REQ_TICK, 3'($urandom_range(0, 7)), rand_pos(),
				random_step()));
		run_random(15);
		finish_phase();

		// Single motor, all-ones ids, no sender gaps.
		gap_pct = 0;
		configure(1'b1, 8'h00, 8'($urandom), 4'd1, '1);
		run_random(18);
		finish_phase();

		gap_pct = 35;
		configure(1'b0, 8'($urandom), 8'($urandom), 4'($urandom_range(1, 8)), '0);
		run_random(18);
		finish_phase();

		// Full frame, no idling anywhere to the end.
		quiet <= 1'b1;
		configure(1'($urandom), 8'($urandom), 8'($urandom), 4'd8, {$urandom, $urandom});
		run_random(22);
		finish_phase();

		$display("Sent %0d requests including %0d ticks; %0d frame words compared",
			requests_sent, ticks_sent, words_checked);
		$display("%0d register settings: motor counts 0, 1, 8 and 15, both control byte %s",
			settings_used, "schemes, steps from 0 to beyond one");
		if (mismatches == 0 && words_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: multi_motor_setpoint_interpolator.f
+incdir+rtl
rtl/mmsi_pkg.sv
rtl/mmsi_ctrl.sv
rtl/mmsi_dp.sv
rtl/multi_motor_setpoint_interpolator.sv
tb/mmsi_checker.sv
tb/tb.sv
